### rtl/core/slm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

  // Widths of the fixed fields and of the internal arithmetic.
  localparam int unsigned SampleW = 16;
  localparam int unsigned AmpW    = 16;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned SumW    = 46;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned NumThr  = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgLevelCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldWin    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgThr0       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgThr1       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgThr2       = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgThr3       = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [4:0]         LevelCountRst = 5'd16;
  localparam logic [7:0]         HoldWinRst    = 8'd10;
  localparam logic [AmpW-1:0]    ThrRst        = 16'hFFFF;
  localparam logic [AmpW-1:0]    AmpMax        = 16'hFFFF;

  // One input word: a stereo sample pair and its end-of-window mark.
  typedef struct packed {
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
    logic                      window_end;
  } in_t;

  // One output word: amplitudes, bars and held peaks of both channels.
  typedef struct packed {
    logic [AmpW-1:0]   left_amplitude;
    logic [AmpW-1:0]   right_amplitude;
    logic [LevelW-1:0] left_bar;
    logic [LevelW-1:0] left_peak;
    logic [LevelW-1:0] right_bar;
    logic [LevelW-1:0] right_peak;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/stereo_level_meter_peak_hold.sv
`timescale 1ns / 1ps
`default_nettype none

// Stereo level meter with peak hold.
// Input words (in_valid_i / in_ready_o) carry one sample pair each. The
// block squares both samples through one shared squarer and adds them to
// saturating per-channel sums of squares, left then right; the next word
// is taken once the block is back in idle. On a marked word each channel
// in turn, left first, has its sum rooted by a shared one-bit-per-cycle
// square root unit, rounded, scanned one level per cycle against the
// thresholds, and its bar, peak and hold count updated. Once both channels
// are done, the output word appears at out_valid_o / out_ready_o. Words
// without the mark give no output word. The output register holds a
// finished word while the receiver stalls, and new input words are still
// taken meanwhile; only the next finished word waits for the register to
// drain. Reset clears the sums, levels and hold counts and loads the
// default configuration. Configuration is written through cfg_we_i /
// cfg_idx_i / cfg_data_i with no wait.
module stereo_level_meter_peak_hold #(
  parameter int unsigned MAX_LEVELS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire slm_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output slm_pkg::out_t                    out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [slm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [slm_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int unsigned SumW   = slm_pkg::SumW;
  localparam int unsigned AmpW   = slm_pkg::AmpW;
  localparam int unsigned LevelW = slm_pkg::LevelW;
  localparam int unsigned RootW  = 24;
  localparam int unsigned RadW   = 2 * RootW;
  localparam int unsigned RemW   = RootW + 2;
  localparam logic [4:0]  LastStep = 5'(RootW - 1);
  localparam logic [4:0]  MaxLv    = 5'(MAX_LEVELS);
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSq    = 3'd1;
  localparam logic [2:0] StRoot  = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StHold  = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  // Configuration registers.
  logic [4:0]      level_count_q;
  logic [7:0]      hold_win_q;
  logic [AmpW-1:0] thr_q [slm_pkg::NumThr];

  // Sequencer and datapath registers.
  logic [2:0]                 state_q, state_d;
  logic                       ch_q, ch_d;
  slm_pkg::in_t               word_q, word_d;
  logic [SumW-1:0]            sum_q [2];
  logic [SumW-1:0]            sum_d [2];
  logic [AmpW-1:0]            amp_q [2];
  logic [AmpW-1:0]            amp_d [2];
  logic [LevelW-1:0]          bar_q [2];
  logic [LevelW-1:0]          bar_d [2];
  logic [LevelW-1:0]          peak_q [2];
  logic [LevelW-1:0]          peak_d [2];
  logic [7:0]                 hold_q [2];
  logic [7:0]                 hold_d [2];
  logic [RadW-1:0]            rad_q, rad_d;
  logic [RemW-1:0]            rem_q, rem_d;
  logic [RootW-1:0]           root_q, root_d;
  logic [4:0]                 step_q, step_d;
  logic [4:0]                 lv_q, lv_d;
  logic                       found_q, found_d;
  logic                       out_valid_q, out_valid_d;
  slm_pkg::out_t              out_q, out_d;

  // Shared squarer and saturating accumulator.
  localparam int unsigned SampleW_L = slm_pkg::SampleW;
  logic [SampleW_L-1:0]       sel_sample;
  logic [SampleW_L:0]         ext;
  logic [SampleW_L:0]         mag;
  logic [2*SampleW_L+1:0]     sq;
  logic [SumW:0]              acc;
  logic [SumW-1:0]            acc_sat;

  // Shared square root step and rounding.
  logic [RemW+1:0]            rem_sh;
  logic [RemW-1:0]            trial;
  logic [RootW:0]             root_rnd;
  logic [AmpW-1:0]            amp_sat;

  // Level scan and hold update.
  logic [4:0]                 lv_lim;
  logic [LevelW-1:0]          lv_idx;
  logic                       lv_hit;
  logic [LevelW-1:0]          peak_base;
  logic [7:0]                 hold_base;
  logic [7:0]                 hold_inc;

  assign sel_sample = ch_q ? word_q.right_sample : word_q.left_sample;
  assign ext        = {sel_sample[SampleW_L-1], sel_sample};
  assign mag        = ext[SampleW_L] ? (~ext + 1'b1) : ext;
  assign sq         = mag * mag;
  assign acc        = {1'b0, sum_q[ch_q]} + (SumW+1)'(sq);
  assign acc_sat    = acc[SumW] ? SumMax : acc[SumW-1:0];

  assign rem_sh   = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign root_rnd = (rem_q > RemW'(root_q)) ? ({1'b0, root_q} + 1'b1) : {1'b0, root_q};
  assign amp_sat  = (root_rnd > (RootW+1)'(slm_pkg::AmpMax)) ? slm_pkg::AmpMax
                                                             : root_rnd[AmpW-1:0];

  assign lv_lim = (level_count_q > MaxLv) ? MaxLv : level_count_q;
  assign lv_idx = lv_q[LevelW-1:0];
  assign lv_hit = amp_q[ch_q] <= thr_q[lv_idx];

  // Bar above the held peak raises it and restarts its hold count.
  always_comb begin
    peak_base = peak_q[ch_q];
    hold_base = hold_q[ch_q];
    if (found_q && (lv_idx > peak_q[ch_q])) begin
      peak_base = lv_idx;
      hold_base = 8'd0;
    end
  end
  assign hold_inc = hold_base + 8'd1;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    word_d      = word_q;
    sum_d       = sum_q;
    amp_d       = amp_q;
    bar_d       = bar_q;
    peak_d      = peak_q;
    hold_d      = hold_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    step_d      = step_q;
    lv_d        = lv_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          word_d  = in_data_i;
          ch_d    = 1'b0;
          state_d = StSq;
        end
      end
      StSq: begin
        sum_d[ch_q] = acc_sat;
        if (!ch_q) begin
          ch_d = 1'b1;
        end else if (word_q.window_end) begin
          // Start the left root; its sum is final and restarts from zero.
          ch_d     = 1'b0;
          rad_d    = RadW'(sum_q[0]);
          sum_d[0] = '0;
          rem_d    = '0;
          root_d   = '0;
          step_d   = '0;
          state_d  = StRoot;
        end else begin
          state_d = StIdle;
        end
      end
      StRoot: begin
        // One root bit per cycle, two radicand bits shifted in.
        if (rem_sh >= (RemW+2)'(trial)) begin
          rem_d  = RemW'(rem_sh - (RemW+2)'(trial));
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[RemW-1:0];
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        rad_d  = {rad_q[RadW-3:0], 2'b00};
        step_d = step_q + 5'd1;
        if (step_q == LastStep) begin
          state_d = StRound;
        end
      end
      StRound: begin
        amp_d[ch_q] = amp_sat;
        lv_d        = '0;
        found_d     = 1'b0;
        state_d     = StScan;
      end
      StScan: begin
        // First level whose threshold is not exceeded.
        if (lv_q >= lv_lim) begin
          state_d = StHold;
        end else if (lv_hit) begin
          found_d = 1'b1;
          state_d = StHold;
        end else begin
          lv_d = lv_q + 5'd1;
        end
      end
      StHold: begin
        if (found_q) begin
          bar_d[ch_q] = lv_idx;
        end
        if (hold_inc >= hold_win_q) begin
          hold_d[ch_q] = 8'd0;
          peak_d[ch_q] = (peak_base != '0) ? (peak_base - 1'b1) : peak_base;
        end else begin
          hold_d[ch_q] = hold_inc;
          peak_d[ch_q] = peak_base;
        end
        if (!ch_q) begin
          ch_d     = 1'b1;
          rad_d    = RadW'(sum_q[1]);
          sum_d[1] = '0;
          rem_d    = '0;
          root_d   = '0;
          step_d   = '0;
          state_d  = StRoot;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // Wait until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d.left_amplitude  = amp_q[0];
          out_d.right_amplitude = amp_q[1];
          out_d.left_bar        = bar_q[0];
          out_d.left_peak       = peak_q[0];
          out_d.right_bar       = bar_q[1];
          out_d.right_peak      = peak_q[1];
          out_valid_d           = 1'b1;
          state_d               = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= slm_pkg::LevelCountRst;
      hold_win_q    <= slm_pkg::HoldWinRst;
      for (int i = 0; i < slm_pkg::NumThr; i++) begin
        thr_q[i] <= slm_pkg::ThrRst;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slm_pkg::CfgLevelCount: level_count_q <= cfg_data_i[4:0];
        slm_pkg::CfgHoldWin:    hold_win_q    <= cfg_data_i[7:0];
        slm_pkg::CfgThr0, slm_pkg::CfgThr1, slm_pkg::CfgThr2, slm_pkg::CfgThr3: begin
          for (int j = 0; j < 4; j++) begin
            thr_q[{cfg_idx_i[1:0] - 2'd2, 2'(j)}] <= cfg_data_i[16*j +: 16];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control and metering state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ch_q        <= 1'b0;
      step_q      <= '0;
      lv_q        <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        sum_q[c]  <= '0;
        bar_q[c]  <= '0;
        peak_q[c] <= '0;
        hold_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      step_q      <= step_d;
      lv_q        <= lv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      bar_q       <= bar_d;
      peak_q      <= peak_d;
      hold_q      <= hold_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    amp_q  <= amp_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

### tb/sv/tb_stereo_level_meter_peak_hold.sv
`timescale 1ns / 1ps

module tb_stereo_level_meter_peak_hold;
  import slm_pkg::*;

  localparam int unsigned SettleCycles = 120;
  localparam int unsigned CycleLimit   = 4000000;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseWords   = 170;
  localparam int unsigned SatWindow    = 64;
  localparam longint unsigned SumMax   = (64'd1 << SumW) - 64'd1;

  // Threshold patterns used by the register loads.
  typedef enum int {
    ThrLinear,
    ThrGeometric,
    ThrSorted,
    ThrScattered,
    ThrZero,
    ThrFull
  } thr_kind_e;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgW-1:0]      cfg_data_i  = '0;

  // Meter state and register copies that track the block.
  logic [SumW-1:0]      energy_q [2];
  logic [LevelW-1:0]    bar_q [2];
  logic [LevelW-1:0]    peak_q [2];
  logic [7:0]           hold_q [2];
  logic [4:0]           level_count_q;
  logic [7:0]           hold_windows_q;
  logic [AmpW-1:0]      thr_q [NumThr];

  out_t                 pending_readings [$];
  out_t                 expected_word;
  bit                   idle_on = 1'b1;
  int                   stall_left = 0;
  int                   sent_pairs = 0;
  int                   readings_checked = 0;
  int                   config_loads = 0;
  int                   mismatches = 0;

  stereo_level_meter_peak_hold #(
    .MAX_LEVELS(16)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is stopped here if the block hangs.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("cycle limit reached with %0d readings pending", pending_readings.size());
    $display("status: fail");
    $finish;
  end

  // Square of the magnitude of a two's complement sample.
  function automatic longint unsigned square_of(logic [SampleW-1:0] raw);
    longint unsigned mag;
    mag = raw[SampleW-1] ? (64'h10000 - raw) : raw;
    return mag * mag;
  endfunction

  // Integer square root, rounded to nearest and saturated to the amplitude range.
  function automatic logic [AmpW-1:0] rounded_root(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    for (int k = 23; k >= 0; k--) begin
      b = 64'd1 << k;
      if ((r + b) * (r + b) <= x) r += b;
    end
    if (x - r * r > r) r++;
    if (r > AmpMax) r = AmpMax;
    return r[AmpW-1:0];
  endfunction

  // Level scan, peak capture and hold count update for one channel.
  task automatic update_channel(int ch, logic [AmpW-1:0] amp);
    int n;
    bit hit;
    n = (level_count_q > NumThr) ? NumThr : level_count_q;
    hit = 1'b0;
    for (int i = 0; i < NumThr; i++) begin
      if (!hit && i < n && amp <= thr_q[i]) begin
        hit = 1'b1;
        bar_q[ch] = LevelW'(i);
        if (i > peak_q[ch]) begin
          peak_q[ch] = LevelW'(i);
          hold_q[ch] = '0;
        end
      end
    end
    hold_q[ch] = hold_q[ch] + 8'd1;
    if (hold_q[ch] >= hold_windows_q) begin
      hold_q[ch] = '0;
      if (peak_q[ch] != '0) peak_q[ch] = peak_q[ch] - 1'b1;
    end
  endtask

  // Accumulates one accepted pair and queues a reading at the end of a window.
  task automatic absorb_pair(in_t w);
    longint unsigned acc;
    logic [SampleW-1:0] raw [2];
    logic [AmpW-1:0] amp [2];
    out_t rd;
    raw[0] = w.left_sample;
    raw[1] = w.right_sample;
    for (int ch = 0; ch < 2; ch++) begin
      acc = energy_q[ch] + square_of(raw[ch]);
      if (acc > SumMax) acc = SumMax;
      energy_q[ch] = acc[SumW-1:0];
    end
    sent_pairs++;
    if (w.window_end) begin
      for (int ch = 0; ch < 2; ch++) begin
        amp[ch] = rounded_root(energy_q[ch]);
        energy_q[ch] = '0;
        update_channel(ch, amp[ch]);
      end
      rd.left_amplitude  = amp[0];
      rd.right_amplitude = amp[1];
      rd.left_bar        = bar_q[0];
      rd.left_peak       = peak_q[0];
      rd.right_bar       = bar_q[1];
      rd.right_peak      = peak_q[1];
      pending_readings.push_back(rd);
    end
  endtask

  // Sender gap: mostly none or short, now and then long.
  function automatic int gap_cycles();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t make_pair(logic [SampleW-1:0] l, logic [SampleW-1:0] r, logic e);
    in_t w;
    w.left_sample  = l;
    w.right_sample = r;
    w.window_end   = e;
    return w;
  endfunction

  // Offers one word and waits until the block takes it.
  task automatic send_pair(in_t w);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_pair(w);
  endtask

  // Drops valid and waits until every reading is out and the block is quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [255:0] make_thresholds(thr_kind_e kind, int unsigned step);
    int unsigned v [16];
    int unsigned t;
    int j;
    logic [255:0] thr_all;
    for (int i = 0; i < 16; i++) begin
      case (kind)
        ThrLinear:    v[i] = (i + 1) * step - 1;
        ThrGeometric: v[i] = (step << i) - 1;
        ThrSorted,
        ThrScattered: v[i] = $urandom_range(0, 65535);
        ThrZero:      v[i] = 0;
        default:      v[i] = 65535;
      endcase
      if (v[i] > 65535) v[i] = 65535;
    end
    if (kind == ThrSorted) begin
      for (int i = 1; i < 16; i++) begin
        t = v[i];
        j = i;
        while (j > 0 && v[j-1] > t) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = t;
      end
    end
    for (int i = 0; i < 16; i++) thr_all[16*i +: 16] = v[i][15:0];
    return thr_all;
  endfunction

  // Writes all six registers on consecutive cycles while the block is idle.
  task automatic load_config(logic [4:0] lc, logic [7:0] hw, logic [255:0] thr_all);
    logic [CfgW-1:0] data [6];
    logic [CfgIdxW-1:0] idx [6];
    settle();
    idx[0] = CfgLevelCount;
    idx[1] = CfgHoldWin;
    idx[2] = CfgThr0;
    idx[3] = CfgThr1;
    idx[4] = CfgThr2;
    idx[5] = CfgThr3;
    // Unused upper bits carry random junk, which the block must ignore.
    data[0] = {$urandom, $urandom};
    data[0][4:0] = lc;
    data[1] = {$urandom, $urandom};
    data[1][7:0] = hw;
    for (int k = 0; k < 4; k++) data[k+2] = thr_all[64*k +: 64];
    for (int k = 0; k < 6; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= data[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    level_count_q  = lc;
    hold_windows_q = hw;
    for (int i = 0; i < NumThr; i++) thr_q[i] = thr_all[16*i +: 16];
    config_loads++;
  endtask

  function automatic int pick_scale();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 7) return 1;
    if (r < 13) return 2;
    return 3;
  endfunction

  function automatic logic [SampleW-1:0] rand_sample(int scale);
    int lim;
    int v;
    case (scale)
      0:       return '0;
      1:       lim = 255;
      2:       lim = 4095;
      default: return SampleW'($urandom);
    endcase
    v = $urandom_range(0, 2 * lim) - lim;
    return SampleW'(v);
  endfunction

  // With reset registers every amplitude fits level 0.
  task automatic test_reset_defaults();
    send_pair(make_pair(16'h0000, 16'h0000, 1'b1));
    send_pair(make_pair(16'h8000, 16'h7FFF, 1'b0));
    send_pair(make_pair(16'h7FFF, 16'h8000, 1'b1));
  endtask

  // Sample extremes, saturated amplitude and root rounding.
  task automatic test_sample_extremes();
    load_config(5'd16, 8'd3, make_thresholds(ThrLinear, 4096));
    send_pair(make_pair(16'hFFFF, 16'h0001, 1'b1));
    for (int j = 0; j < 4; j++) send_pair(make_pair(16'h8000, 16'h8000, j == 3));
    send_pair(make_pair(16'h0001, 16'h0001, 1'b0));
    send_pair(make_pair(16'h0001, 16'h0001, 1'b0));
    send_pair(make_pair(16'h0001, 16'h0000, 1'b1));
  endtask

  // Amplitude above every scanned threshold keeps the bar and does not raise the peak.
  task automatic test_no_level();
    load_config(5'd2, 8'd3, make_thresholds(ThrLinear, 4096));
    send_pair(make_pair(16'h4E20, 16'h0064, 1'b1));
    send_pair(make_pair(16'h7FFF, 16'h0000, 1'b1));
  endtask

  // A level count of zero scans nothing; one above the maximum scans all levels.
  task automatic test_level_count_bounds();
    load_config(5'd0, 8'd3, make_thresholds(ThrLinear, 4096));
    send_pair(make_pair(16'h1000, 16'h0000, 1'b1));
    load_config(5'd31, 8'd3, make_thresholds(ThrLinear, 4096));
    send_pair(make_pair(16'h7FFF, 16'h8000, 1'b1));
  endtask

  // A hold of zero decays on every window; the longest hold keeps the peak over the window sent.
  task automatic test_fast_decay();
    load_config(5'd16, 8'd0, make_thresholds(ThrLinear, 4096));
    send_pair(make_pair(16'h8000, 16'h8000, 1'b1));
    for (int j = 0; j < 3; j++) send_pair(make_pair(16'h0000, 16'h0000, 1'b1));
    load_config(5'd16, 8'd255, make_thresholds(ThrLinear, 4096));
    send_pair(make_pair(16'h0000, 16'h0000, 1'b1));
  endtask

  // One long full-scale window whose root lies far above the amplitude range,
  // then an empty window to show the sums were cleared.
  task automatic test_sum_saturation();
    idle_on = 1'b0;
    load_config(5'd16, 8'd10, make_thresholds(ThrLinear, 4096));
    for (int j = 0; j < SatWindow; j++) begin
      send_pair(make_pair(16'h8000, 16'h0001, j == SatWindow - 1));
    end
    send_pair(make_pair(16'h0000, 16'h0000, 1'b1));
    idle_on = 1'b1;
  endtask

  // Random windows under a series of register settings, with some noise bursts.
  task automatic test_random_windows();
    logic [4:0] lc;
    logic [7:0] hw;
    int len;
    int ls;
    int rs;
    int phase_words;
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       lc = 5'd1;
        1:       lc = 5'd16;
        2:       lc = 5'd31;
        3:       lc = 5'd0;
        default: lc = 5'($urandom_range(1, 16));
      endcase
      case (p)
        0:       hw = 8'd255;
        1:       hw = 8'd1;
        2:       hw = 8'd0;
        default: hw = 8'($urandom_range(1, 12));
      endcase
      load_config(lc, hw, make_thresholds(thr_kind_e'(p % 6), $urandom_range(1, 4096)));
      idle_on = (p % 4 != 3);
      phase_words = 0;
      while (phase_words < PhaseWords) begin
        if ($urandom_range(0, 99) < 15) begin
          len = $urandom_range(1, 6);
          for (int j = 0; j < len; j++) begin
            send_pair(make_pair(SampleW'($urandom), SampleW'($urandom),
                                $urandom_range(0, 3) == 0));
          end
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          ls = pick_scale();
          rs = pick_scale();
          for (int j = 0; j < len; j++) begin
            send_pair(make_pair(rand_sample(ls), rand_sample(rs), j == len - 1));
          end
        end
        phase_words += len;
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic compare_field(string name, logic [AmpW-1:0] want, logic [AmpW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Output side: checks each accepted word and applies random stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_readings.size() == 0) begin
          $error("output word with no reading pending: %h", out_data_o);
          mismatches++;
        end else begin
          expected_word = pending_readings.pop_front();
          compare_field("left_amplitude", expected_word.left_amplitude,
                        out_data_o.left_amplitude);
          compare_field("right_amplitude", expected_word.right_amplitude,
                        out_data_o.right_amplitude);
          compare_field("left_bar", expected_word.left_bar, out_data_o.left_bar);
          compare_field("left_peak", expected_word.left_peak, out_data_o.left_peak);
          compare_field("right_bar", expected_word.right_bar, out_data_o.right_bar);
          compare_field("right_peak", expected_word.right_peak, out_data_o.right_peak);
          readings_checked++;
        end
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!idle_on || $urandom_range(0, 99) < 75) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  initial begin
    level_count_q  = LevelCountRst;
    hold_windows_q = HoldWinRst;
    for (int i = 0; i < NumThr; i++) thr_q[i] = ThrRst;
    for (int ch = 0; ch < 2; ch++) begin
      energy_q[ch] = '0;
      bar_q[ch]    = '0;
      peak_q[ch]   = '0;
      hold_q[ch]   = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_sample_extremes();
    test_no_level();
    test_level_count_bounds();
    test_fast_decay();
    test_sum_saturation();
    test_random_windows();
    settle();

    $display("Sent %0d sample pairs under %0d register loads, checked %0d readings.",
             sent_pairs, config_loads, readings_checked);
    $display("Covered sample extremes, saturated amplitudes, level counts 0 to 31 and holds 0 to 255.");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/slm_pkg.sv
rtl/core/stereo_level_meter_peak_hold.sv
tb/sv/tb_stereo_level_meter_peak_hold.sv
